[src/base64_stream_decoder_macros.svh]
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// clocked property, ignored while reset is asserted
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define B64D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, character codes and the sextet map of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    // position of a character within its four-character group
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD,
        PH_FOURTH
    } t_phase;

    // one input word as held in the input register
    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } t_in_word;

    // one decode result handed to the output register
    typedef struct packed {
        logic       present;
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
    } t_result;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    localparam logic [5:0] SX_LOWER_BASE = 6'd26;
    localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS       = 6'd62;
    localparam logic [5:0] SX_SLASH      = 6'd63;

    // liberal map: both alphabets accepted, anything unknown decodes as zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] diff;
        logic [5:0] val;
        diff = 8'd0;
        val  = 6'd0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            diff = c - CH_UPPER_A;
            val  = diff[5:0];
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            diff = c - CH_LOWER_A;
            val  = diff[5:0] + SX_LOWER_BASE;
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            diff = c - CH_DIGIT_0;
            val  = diff[5:0] + SX_DIGIT_BASE;
        end else if (c inside {CH_PLUS, CH_MINUS}) begin
            val = SX_PLUS;
        end else if (c inside {CH_SLASH, CH_UNDER}) begin
            val = SX_SLASH;
        end
        return val;
    endfunction

    function automatic logic is_pad(input logic [7:0] c);
        return (c inside {CH_EQUAL, CH_DOT});
    endfunction

endpackage

[src/b64d_in_reg.sv]
// ----------------------------------------------------------------------------
// b64d_in_reg
// input register stage, holds one word until the decode stage takes it
// ----------------------------------------------------------------------------
module b64d_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  b64d_pkg::t_in_word i_word,
    input  logic               i_take,
    output logic               o_stall,
    output logic               o_held,
    output b64d_pkg::t_in_word o_word
);

    logic               r_held;
    b64d_pkg::t_in_word r_word;
    logic               w_load;

    // free when empty or when the held word leaves this cycle
    assign o_stall = r_held && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (w_load) begin
            r_held <= 1'b1;
        end else if (i_take) begin
            r_held <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= i_word;
        end
    end

    assign o_held = r_held;
    assign o_word = r_word;

endmodule

[src/b64d_decode.sv]
// ----------------------------------------------------------------------------
// b64d_decode
// group state and the shift-merge that turns sextets into bytes
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  b64d_pkg::t_in_word i_word,
    output b64d_pkg::t_result  o_result
);

    b64d_pkg::t_phase r_phase, n_phase;
    logic [5:0]       r_held_sextet, n_held_sextet;
    logic             r_pad_seen, n_pad_seen;

    logic [5:0] w_sx;
    logic       w_pad;
    logic       w_emit;
    logic [7:0] w_byte;

    assign w_sx  = b64d_pkg::sextet_of(i_word.in_char);
    assign w_pad = b64d_pkg::is_pad(i_word.in_char);

    always_comb begin
        n_phase       = b64d_pkg::t_phase'(r_phase + 2'd1);
        n_held_sextet = r_held_sextet;
        n_pad_seen    = r_pad_seen;
        w_emit        = 1'b0;
        w_byte        = 8'd0;
        case (r_phase)
            b64d_pkg::PH_FIRST: begin
                n_held_sextet = w_sx;
                n_pad_seen    = 1'b0;
            end
            b64d_pkg::PH_SECOND: begin
                w_byte        = {r_held_sextet, w_sx[5:4]};
                w_emit        = 1'b1;
                n_held_sextet = w_sx;
            end
            b64d_pkg::PH_THIRD: begin
                if (w_pad) begin
                    n_pad_seen = 1'b1;
                end else begin
                    w_byte        = {r_held_sextet[3:0], w_sx[5:2]};
                    w_emit        = 1'b1;
                    n_held_sextet = w_sx;
                end
            end
            b64d_pkg::PH_FOURTH: begin
                if (!r_pad_seen && !w_pad) begin
                    w_byte = {r_held_sextet[1:0], w_sx};
                    w_emit = 1'b1;
                end
                n_pad_seen = 1'b0;
            end
            default: begin
                n_phase = b64d_pkg::PH_FIRST;
            end
        endcase
        // end of string starts a fresh group
        if (i_word.last_char) begin
            n_phase       = b64d_pkg::PH_FIRST;
            n_held_sextet = 6'd0;
            n_pad_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= b64d_pkg::PH_FIRST;
            r_held_sextet <= 6'd0;
            r_pad_seen    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_held_sextet <= n_held_sextet;
            r_pad_seen    <= n_pad_seen;
        end
    end

    assign o_result.present       = w_emit || i_word.last_char;
    assign o_result.out_byte      = w_byte;
    assign o_result.has_byte      = w_emit;
    assign o_result.end_of_string = i_word.last_char;

endmodule

[src/b64d_out_reg.sv]
// ----------------------------------------------------------------------------
// b64d_out_reg
// result register, holds one result until the consumer takes it
// ----------------------------------------------------------------------------
module b64d_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  b64d_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_has_byte,
    output logic              o_end_of_string
);

    logic              r_valid;
    b64d_pkg::t_result r_result;
    logic              w_fill;

    assign o_free = !r_valid || !i_stall;
    assign w_fill = i_load && i_result.present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= w_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_result <= i_result;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_result.out_byte;
    assign o_has_byte      = r_result.has_byte;
    assign o_end_of_string = r_result.end_of_string;

endmodule

[src/base64_stream_decoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder
// liberal base64 decoder, one character per word in, at most one byte out
// ----------------------------------------------------------------------------
// Characters enter one per word and are counted in groups of four; the
// second, third and fourth character of a group each give one decoded byte,
// with '=' or '.' in the third or fourth place suppressing the trailing bytes.
// Both the standard and the url-safe alphabets are accepted and any other
// character decodes as zero. A word marked last always yields a result with
// end_of_string set (carrying a byte or not) and returns the group state to
// its start. Words that give no result are simply absorbed. Throughput is one
// character per cycle: an input register feeds the table map and shift-merge,
// whose result lands in an output register; the stream runs without gaps as
// long as the consumer keeps i_stall low. A stall on the output holds the
// result and the one word behind it; further words then see o_stall.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character side
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_last_char,
    // byte side
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_string
);

    b64d_pkg::t_in_word w_in_word;
    b64d_pkg::t_in_word w_held_word;
    b64d_pkg::t_result  w_result;
    logic               w_held;
    logic               w_out_free;
    logic               w_step;

    assign w_in_word.in_char   = i_in_char;
    assign w_in_word.last_char = i_last_char;

    // the held word is decoded when the result register can take its result
    assign w_step = w_held && w_out_free;

    b64d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (w_in_word),
        .i_take  (w_step),
        .o_stall (o_stall),
        .o_held  (w_held),
        .o_word  (w_held_word)
    );

    // group phase, previous sextet and pad mark advance once per decoded word
    b64d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (w_held_word),
        .o_result (w_result)
    );

    b64d_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_step),
        .i_result        (w_result),
        .i_stall         (i_stall),
        .o_free          (w_out_free),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_string (o_end_of_string)
    );

endmodule

[src/b64d_checker.sv]
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks of the base64 stream decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_in_char,
    input logic       i_last_char,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_has_byte,
    input logic       o_end_of_string
);

    // a stalled result stays offered
    `B64D_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped under stall")

    // a result without a byte only marks the end of the string
    `B64D_ASSERT(a_empty_is_end, i_clk, i_rst_n, o_valid && !o_has_byte |-> o_end_of_string, "empty result without end of string")

    // an empty result carries a zero byte
    `B64D_ASSERT(a_empty_zero, i_clk, i_rst_n, o_valid && !o_has_byte |-> o_out_byte == 8'd0, "empty result with nonzero byte")

    // reset leaves nothing on the output
    `B64D_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
